FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is low
`define MP2D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the house clock and reset names
`define MP2D_ASSERT_STD(lbl, prop, msg) \
  `MP2D_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/mp2d_pkg.sv
// ---------------------------------------------------------------------------
// mp2d_pkg
// Shared widths, constants, register codes and float compare for the
// 2-D max pooling stream unit.
// ---------------------------------------------------------------------------
package mp2d_pkg;

  localparam int unsigned DEF_MAX_KERNEL = 8;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SK_W      = 4;

  // -9000.0 as single precision, starting point of each window maximum
  localparam logic [PIX_W-1:0] WIN_FLOOR = 32'hC60C_A000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH,
    REG_IN_HEIGHT,
    REG_OUT_WIDTH,
    REG_OUT_HEIGHT,
    REG_STRIDE,
    REG_KERNEL
  } cfg_reg_e;

  // a < b on single-precision patterns; false whenever either is NaN
  function automatic logic fp_lt(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    logic a_nan;
    logic b_nan;
    logic zeros;
    logic res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    zeros = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (a_nan || b_nan || zeros) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/mp2d_if.sv
// ---------------------------------------------------------------------------
// mp2d_if
// Valid/ready channels: pixel beats in, pooled beats out.
// ---------------------------------------------------------------------------
interface mp2d_in_if import mp2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mp2d_out_if import mp2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pooled_value;
  logic [POS_W-1:0] out_col;
  logic [POS_W-1:0] out_row;
  logic             plane_done;

  modport source (output valid, output pooled_value, output out_col, output out_row,
                  output plane_done, input ready);
  modport sink   (input valid, input pooled_value, input out_col, input out_row,
                  input plane_done, output ready);
endinterface

FILE: rtl/max_pool_2d_stream_unit.sv
// ---------------------------------------------------------------------------
// max_pool_2d_stream_unit
// Streaming 2-D max pooling of single-precision values held in one
// partial-maximum RAM, read-modify-write per covering window.
// ---------------------------------------------------------------------------
//  channel   dir  beat
//  pix_in    in   pixel_value, raster order, plane after plane
//  pool_out  out  pooled_value, out_col, out_row, plane_done
//  cfg_*     in   register write, index 0..5, no read-back
//
//  One pixel at a time: it is accepted in S_IDLE, then each covering
//  window takes a RAM read (S_ITER) and a compare and write back
//  (S_MOD); S_ITER also skips windows past the pooled plane edge, steps
//  to the next window row and finishes the pixel.
//  After a register write the input waits while the divider is loaded,
//  then a serial divide rebuilds the window position counters.
//  Reset: asynchronous, active low; RAM contents undefined until written.
//  A full output register holds the walk only on a completing window.
// ---------------------------------------------------------------------------
module max_pool_2d_stream_unit import mp2d_pkg::*; #(
  parameter int unsigned MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  mp2d_in_if.sink              pix_in,
  mp2d_out_if.source           pool_out
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned SR    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned AW    = SR + CW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned DW    = (CW > RW) ? CW : RW;
  localparam int unsigned DCW   = $clog2(DW);
  localparam int unsigned MAXWH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DIM_W = (($clog2(MAXWH + 1) > CFG_W) ? $clog2(MAXWH + 1) : CFG_W) + 1;
  localparam int unsigned KW    = $clog2(MAX_KERNEL + 1);
  localparam int unsigned OFF_W = $clog2(MAX_KERNEL + 16);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_ITER, S_MOD} state_e;

  state_e state_q;

  // configuration
  logic [CFG_W-1:0] in_width_q, in_height_q, out_width_q, out_height_q;
  logic [SK_W-1:0]  stride_q, kernel_q;
  logic             dirty_q;

  // plane position and its window decomposition
  logic [CW-1:0]   col_q, cq_q, cq0_q;
  logic [RW-1:0]   row_q, rq_q;
  logic [SK_W-1:0] cph_q, rph_q, cph0_q;

  // window walk
  logic [OFF_W-1:0] ro_q, co_q;
  logic [RW-1:0]    wr_q;
  logic [CW-1:0]    wc_q;
  logic             wr_neg_q, wc_neg_q;
  logic [PIX_W-1:0] px_q;

  // serial divider
  logic [DW-1:0]   dvc_q, dvr_q;
  logic [SK_W:0]   remc_q, remr_q;
  logic [DCW-1:0]  dcnt_q;

  // output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_val_q;
  logic [POS_W-1:0] out_col_q, out_row_q;
  logic             out_done_q;

  // RAM
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_q;
  logic [AW-1:0]    addr;
  logic             mem_re, mem_we;

  // saturated register values
  logic [DIM_W-1:0] iw_s, ih_s, ow_s, oh_s;
  logic [SK_W-1:0]  s_v;
  logic [KW-1:0]    k_v;
  logic [OFF_W-1:0] km1;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v,
                                               input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (DIM_W'(v) > hi) begin
      r = hi;
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // one restoring divide step: {remainder, dividend/quotient}
  function automatic logic [SK_W+DW:0] div_step(input logic [SK_W:0] rem,
                                                input logic [DW-1:0] dvd,
                                                input logic [SK_W-1:0] dv);
    logic [SK_W:0] rt;
    logic          ge;
    rt = {rem[SK_W-1:0], dvd[DW-1]};
    ge = rt >= {1'b0, dv};
    return {(ge ? rt - {1'b0, dv} : rt), dvd[DW-2:0], ge};
  endfunction

  assign iw_s = sat_dim(in_width_q, DIM_W'(MAX_WIDTH));
  assign ih_s = sat_dim(in_height_q, DIM_W'(MAX_HEIGHT));
  assign ow_s = sat_dim(out_width_q, DIM_W'(MAX_WIDTH));
  assign oh_s = sat_dim(out_height_q, DIM_W'(MAX_HEIGHT));
  assign s_v  = (stride_q == '0) ? SK_W'(1) : stride_q;
  assign k_v  = (kernel_q == '0) ? KW'(1) :
                ((32'(kernel_q) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_q));
  assign km1  = OFF_W'(k_v) - OFF_W'(1);

  // position advance
  logic            col_last, row_last;
  logic [SK_W-1:0] cph_inc, rph_inc;
  assign col_last = (DIM_W'(col_q) + DIM_W'(1)) >= iw_s;
  assign row_last = (DIM_W'(row_q) + DIM_W'(1)) >= ih_s;
  assign cph_inc  = cph_q + SK_W'(1);
  assign rph_inc  = rph_q + SK_W'(1);

  // walk decisions
  logic row_end, col_end, win_out, in_acc;
  assign in_acc  = pix_in.valid && pix_in.ready;
  assign row_end = wr_neg_q || (ro_q > km1);
  assign col_end = wc_neg_q || (co_q > km1);
  assign win_out = (DIM_W'(wr_q) >= oh_s) || (DIM_W'(wc_q) >= ow_s);

  // modify stage
  logic [PIX_W-1:0] cur_max, new_max;
  logic             win_done, stall;
  assign cur_max  = ((ro_q == '0) && (co_q == '0)) ? WIN_FLOOR : rd_q;
  assign new_max  = fp_lt(px_q, cur_max) ? cur_max : px_q;
  assign win_done = (ro_q == km1) && (co_q == km1);
  assign stall    = win_done && out_valid_q && !pool_out.ready;

  assign addr   = {SR'(wr_q), wc_q};
  assign mem_re = (state_q == S_ITER) && !row_end && !col_end && !win_out;
  assign mem_we = (state_q == S_MOD) && !stall;

  logic [SK_W+DW:0] stc, str;
  assign stc = div_step(remc_q, dvc_q, s_v);
  assign str = div_step(remr_q, dvr_q, s_v);

  assign pix_in.ready = (state_q == S_IDLE) && !dirty_q;

  // RAM port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= new_max;
    end
    if (mem_re) begin
      rd_q <= mem[addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= pix_in.pixel_value;
    end
    if (mem_we && win_done) begin
      out_val_q  <= new_max;
      out_col_q  <= POS_W'(wc_q);
      out_row_q  <= POS_W'(wr_q);
      out_done_q <= (DIM_W'(wr_q) == oh_s - DIM_W'(1)) &&
                    (DIM_W'(wc_q) == ow_s - DIM_W'(1));
    end
  end

  // control: sequencer, counters, configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_width_q   <= CFG_W'(32);
      in_height_q  <= CFG_W'(32);
      out_width_q  <= CFG_W'(16);
      out_height_q <= CFG_W'(16);
      stride_q     <= SK_W'(2);
      kernel_q     <= SK_W'(2);
      dirty_q      <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
      cq_q         <= '0;
      rq_q         <= '0;
      cph_q        <= '0;
      rph_q        <= '0;
      cq0_q        <= '0;
      cph0_q       <= '0;
      ro_q         <= '0;
      co_q         <= '0;
      wr_q         <= '0;
      wc_q         <= '0;
      wr_neg_q     <= 1'b0;
      wc_neg_q     <= 1'b0;
      dvc_q        <= '0;
      dvr_q        <= '0;
      remc_q       <= '0;
      remr_q       <= '0;
      dcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pool_out.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (dirty_q) begin
            dirty_q <= 1'b0;
            dvc_q   <= DW'(col_q);
            dvr_q   <= DW'(row_q);
            remc_q  <= '0;
            remr_q  <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end else if (in_acc) begin
            // start the walk at the lowest-right window covering the pixel
            ro_q     <= OFF_W'(rph_q);
            wr_q     <= rq_q;
            wr_neg_q <= 1'b0;
            co_q     <= OFF_W'(cph_q);
            wc_q     <= cq_q;
            wc_neg_q <= 1'b0;
            cph0_q   <= cph_q;
            cq0_q    <= cq_q;
            state_q  <= S_ITER;
            if (col_last) begin
              col_q <= '0;
              cq_q  <= '0;
              cph_q <= '0;
              if (row_last) begin
                row_q <= '0;
                rq_q  <= '0;
                rph_q <= '0;
              end else begin
                row_q <= row_q + RW'(1);
                if (rph_inc == s_v) begin
                  rph_q <= '0;
                  rq_q  <= rq_q + RW'(1);
                end else begin
                  rph_q <= rph_inc;
                end
              end
            end else begin
              col_q <= col_q + CW'(1);
              if (cph_inc == s_v) begin
                cph_q <= '0;
                cq_q  <= cq_q + CW'(1);
              end else begin
                cph_q <= cph_inc;
              end
            end
          end
        end

        S_DIV: begin
          remc_q <= stc[SK_W+DW:DW];
          dvc_q  <= stc[DW-1:0];
          remr_q <= str[SK_W+DW:DW];
          dvr_q  <= str[DW-1:0];
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DCW'(DW - 1)) begin
            cq_q    <= CW'(stc[DW-1:0]);
            cph_q   <= SK_W'(stc[SK_W+DW:DW]);
            rq_q    <= RW'(str[DW-1:0]);
            rph_q   <= SK_W'(str[SK_W+DW:DW]);
            state_q <= S_IDLE;
          end
        end

        S_ITER: begin
          if (row_end) begin
            state_q <= S_IDLE;
          end else if (col_end) begin
            // next window row up
            ro_q     <= ro_q + OFF_W'(s_v);
            wr_neg_q <= (wr_q == '0);
            wr_q     <= wr_q - RW'(1);
            co_q     <= OFF_W'(cph0_q);
            wc_q     <= cq0_q;
            wc_neg_q <= 1'b0;
          end else if (win_out) begin
            co_q     <= co_q + OFF_W'(s_v);
            wc_neg_q <= (wc_q == '0);
            wc_q     <= wc_q - CW'(1);
          end else begin
            state_q <= S_MOD;
          end
        end

        S_MOD: begin
          if (!stall) begin
            if (win_done) begin
              out_valid_q <= 1'b1;
            end
            co_q     <= co_q + OFF_W'(s_v);
            wc_neg_q <= (wc_q == '0);
            wc_q     <= wc_q - CW'(1);
            state_q  <= S_ITER;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // register writes; any write rebuilds the position split
      if (cfg_we_i) begin
        dirty_q <= 1'b1;
        case (cfg_idx_i)
          REG_IN_WIDTH:   in_width_q   <= cfg_data_i;
          REG_IN_HEIGHT:  in_height_q  <= cfg_data_i;
          REG_OUT_WIDTH:  out_width_q  <= cfg_data_i;
          REG_OUT_HEIGHT: out_height_q <= cfg_data_i;
          REG_STRIDE:     stride_q     <= cfg_data_i[SK_W-1:0];
          REG_KERNEL:     kernel_q     <= cfg_data_i[SK_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  assign pool_out.valid        = out_valid_q;
  assign pool_out.pooled_value = out_val_q;
  assign pool_out.out_col      = out_col_q;
  assign pool_out.out_row      = out_row_q;
  assign pool_out.plane_done   = out_done_q;

endmodule

FILE: rtl/mp2d_checker.sv
// ---------------------------------------------------------------------------
// mp2d_checker
// Port-level checks on the pooling unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mp2d_checker import mp2d_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] out_value_i,
  input logic [POS_W-1:0] out_col_i,
  input logic [POS_W-1:0] out_row_i
);

  // one pixel in flight: busy right after a beat is taken
  `MP2D_ASSERT_STD(a_busy_after_beat, (in_valid_i && in_ready_i) |=> !in_ready_i,
                   "input taken twice in a row")

  // a register write forces the position rebuild before the next beat
  `MP2D_ASSERT_STD(a_cfg_blocks, cfg_we_i |=> !in_ready_i,
                   "input ready right after register write")

  // stalled result stays and holds
  `MP2D_ASSERT_STD(a_out_hold, (out_valid_i && !out_ready_i) |=> out_valid_i,
                   "result dropped while stalled")
  `MP2D_ASSERT_STD(a_out_stable,
                   (out_valid_i && !out_ready_i) |=>
                   ($stable(out_value_i) && $stable(out_col_i) && $stable(out_row_i)),
                   "result changed while stalled")

endmodule

bind max_pool_2d_stream_unit mp2d_checker u_mp2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_valid_i  (pix_in.valid),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (pool_out.valid),
  .out_ready_i (pool_out.ready),
  .out_value_i (pool_out.pooled_value),
  .out_col_i   (pool_out.out_col),
  .out_row_i   (pool_out.out_row)
);
